// ----- src/indexed_circular_doubly_linked_list_assert.svh -----
// Assertion macros for the indexed circular doubly linked list checker.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef INDEXED_CIRCULAR_DOUBLY_LINKED_LIST_ASSERT_SVH
`define INDEXED_CIRCULAR_DOUBLY_LINKED_LIST_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ICDL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ICDL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/icdl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the indexed circular doubly linked list.
// No dependencies; used by the controller, the datapath, the top level and the checker.
package icdl_pkg;

    localparam int NODES  = 1024;
    localparam int IDX_W  = 10;
    localparam int LINK_W = 11;
    localparam int CNT_W  = 11;
    localparam int CMD_W  = 3;

    localparam logic [LINK_W-1:0] LINK_NIL = {LINK_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_INS_HEAD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RM_ITEM   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RM_HEAD   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RM_TAIL   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_INIT      = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] item_index;
        logic [IDX_W-1:0] start_index;
        logic [CNT_W-1:0] init_count;
    } request_t;

    typedef struct packed {
        logic [IDX_W-1:0] removed_index;
        logic             removed_valid;
        logic             error;
        logic [IDX_W-1:0] head_index;
        logic             list_empty;
        logic [CNT_W-1:0] entry_count;
    } result_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SET_ERR,
        OP_INS_FIRST,
        OP_RD_HEAD,
        OP_INS_LINK,
        OP_INS_CLOSE,
        OP_RM_PICK,
        OP_RM_SINGLE,
        OP_RM_SPLICE,
        OP_RM_NIL,
        OP_INIT_EMPTY,
        OP_INIT_WALK,
        OP_INIT_CLOSE,
        OP_REPORT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_insert;
        logic is_remove;
        logic is_init;
        logic full;
        logic has_head;
        logic init_zero;
        logic single;
        logic walk_last;
    } dp_status_t;

endpackage

// ----- src/indexed_circular_doubly_linked_list.sv -----
`timescale 1ns / 1ps
// Top level of the indexed circular doubly linked list over a 1024-node pool.
// Depends on icdl_pkg, icdl_ctrl and icdl_datapath.
//
// Usage:
//   Command channel: a request transfers at a rising edge with start high and
//   busy low. busy stays high until the command's result has been produced.
//   Result channel: done is high for exactly one cycle with response valid;
//   the receiver cannot stall it and must take it in that cycle.
//   Config channel: cfg_data (max_entries) transfers when cfg_valid and
//   cfg_ready are high; cfg_ready is high whenever the block is idle.
// Time from transfer to done, also the spacing of back-to-back commands,
// follows the path through the controller states: error cases, insert into
// an empty list, zero-length initialize and unknown codes go from decode to
// report; insert adds link and close; remove adds pick, splice and nil, or
// pick and single for a lone node; a nonzero initialize adds the walk and
// close. The path is set by the link memories, each with one read and one
// write port and registered read data, and the initialize walk writes one
// node per cycle. A new request may transfer in the cycle done is shown.
// Reset clears head, count and valid state and sets max_entries to 1024;
// the link memories are not cleared and hold no defined value until written.
module indexed_circular_doubly_linked_list (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  icdl_pkg::request_t         request,
    output logic                       done,
    output icdl_pkg::result_t          response,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [icdl_pkg::CNT_W-1:0] cfg_data
);
    import icdl_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    logic       busy_int;

    icdl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (dp_status),
        .cmd    (dp_cmd),
        .busy   (busy_int)
    );

    icdl_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (dp_cmd),
        .request  (request),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .status   (dp_status),
        .response (response),
        .done     (done)
    );

    assign busy      = busy_int;
    assign cfg_ready = !busy_int;

endmodule

// ----- src/icdl_ctrl.sv -----
`timescale 1ns / 1ps
// Command sequencer for the linked list: steps each command through its
// link-memory reads and writes. Depends on icdl_pkg for command and status types.
module icdl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  icdl_pkg::dp_status_t status,
    output icdl_pkg::dp_cmd_t    cmd,
    output logic                 busy
);
    import icdl_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE       = 11'b000_0000_0001,
        ST_DECODE     = 11'b000_0000_0010,
        ST_INS_LINK   = 11'b000_0000_0100,
        ST_INS_CLOSE  = 11'b000_0000_1000,
        ST_RM_PICK    = 11'b000_0001_0000,
        ST_RM_SINGLE  = 11'b000_0010_0000,
        ST_RM_SPLICE  = 11'b000_0100_0000,
        ST_RM_NIL     = 11'b000_1000_0000,
        ST_INIT_WALK  = 11'b001_0000_0000,
        ST_INIT_CLOSE = 11'b010_0000_0000,
        ST_REPORT     = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_REPORT;
                if (status.is_insert)
                begin
                    if (status.full)
                    begin
                        cmd.op = OP_SET_ERR;
                    end
                    else if (!status.has_head)
                    begin
                        cmd.op = OP_INS_FIRST;
                    end
                    else
                    begin
                        cmd.op     = OP_RD_HEAD;
                        state_next = ST_INS_LINK;
                    end
                end
                else if (status.is_remove)
                begin
                    if (!status.has_head)
                    begin
                        cmd.op = OP_SET_ERR;
                    end
                    else
                    begin
                        cmd.op     = OP_RD_HEAD;
                        state_next = ST_RM_PICK;
                    end
                end
                else if (status.is_init)
                begin
                    if (status.init_zero)
                    begin
                        cmd.op = OP_INIT_EMPTY;
                    end
                    else
                    begin
                        state_next = ST_INIT_WALK;
                    end
                end
            end
            ST_INS_LINK:
            begin
                cmd.op     = OP_INS_LINK;
                state_next = ST_INS_CLOSE;
            end
            ST_INS_CLOSE:
            begin
                cmd.op     = OP_INS_CLOSE;
                state_next = ST_REPORT;
            end
            ST_RM_PICK:
            begin
                cmd.op     = OP_RM_PICK;
                state_next = status.single ? ST_RM_SINGLE : ST_RM_SPLICE;
            end
            ST_RM_SINGLE:
            begin
                cmd.op     = OP_RM_SINGLE;
                state_next = ST_REPORT;
            end
            ST_RM_SPLICE:
            begin
                cmd.op     = OP_RM_SPLICE;
                state_next = ST_RM_NIL;
            end
            ST_RM_NIL:
            begin
                cmd.op     = OP_RM_NIL;
                state_next = ST_REPORT;
            end
            ST_INIT_WALK:
            begin
                cmd.op = OP_INIT_WALK;
                if (status.walk_last)
                begin
                    state_next = ST_INIT_CLOSE;
                end
            end
            ST_INIT_CLOSE:
            begin
                cmd.op     = OP_INIT_CLOSE;
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                cmd.op     = OP_REPORT;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- src/icdl_datapath.sv -----
`timescale 1ns / 1ps
// Link memories, head, count and limit registers, and the result register.
// Depends on icdl_pkg; driven one operation per cycle by icdl_ctrl.
module icdl_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  icdl_pkg::dp_cmd_t          cmd,
    input  icdl_pkg::request_t         request,
    input  logic                       cfg_we,
    input  logic [icdl_pkg::CNT_W-1:0] cfg_data,
    output icdl_pkg::dp_status_t       status,
    output icdl_pkg::result_t          response,
    output logic                       done
);
    import icdl_pkg::*;

    localparam logic [CNT_W-1:0] POOL_SIZE = CNT_W'(NODES);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NODES - 1);

    // link stores, no reset: entries are defined once written
    logic [LINK_W-1:0] prev_mem [NODES];
    logic [LINK_W-1:0] next_mem [NODES];

    logic [LINK_W-1:0] rd_prev_reg;
    logic [LINK_W-1:0] rd_next_reg;

    logic [CMD_W-1:0]  cmd_reg;
    logic [IDX_W-1:0]  item_reg;
    logic [IDX_W-1:0]  start_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  walk_reg;
    logic [IDX_W-1:0]  victim_reg;
    logic [IDX_W-1:0]  pv_reg;
    logic [IDX_W-1:0]  succ_reg;

    logic [IDX_W-1:0]  head_reg;
    logic              head_valid_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  max_reg;
    logic              err_reg;
    logic [IDX_W-1:0]  removed_reg;
    logic              rvalid_reg;
    result_t           resp_reg;
    logic              done_reg;

    logic [CNT_W-1:0]  limit;
    logic [CNT_W-1:0]  req_n;
    logic [IDX_W-1:0]  victim_next;
    logic [IDX_W-1:0]  walk_node;
    logic [IDX_W-1:0]  last_node;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              prev_we;
    logic [IDX_W-1:0]  prev_wa;
    logic [LINK_W-1:0] prev_wd;
    logic              next_we;
    logic [IDX_W-1:0]  next_wa;
    logic [LINK_W-1:0] next_wd;

    assign limit     = (max_reg > POOL_SIZE) ? POOL_SIZE : max_reg;
    assign req_n     = (request.init_count < limit) ? request.init_count : limit;
    assign walk_node = start_reg + walk_reg[IDX_W-1:0];
    assign last_node = start_reg + IDX_W'(n_reg - CNT_W'(1));

    always_comb
    begin
        case (cmd_reg)
            CMD_RM_ITEM: victim_next = item_reg;
            CMD_RM_HEAD: victim_next = head_reg;
            default:     victim_next = rd_prev_reg[IDX_W-1:0];
        endcase
    end

    always_comb
    begin
        status.is_insert = (cmd_reg inside {CMD_INS_HEAD, CMD_INS_TAIL});
        status.is_remove = (cmd_reg inside {CMD_RM_ITEM, CMD_RM_HEAD, CMD_RM_TAIL});
        status.is_init   = (cmd_reg == CMD_INIT);
        status.full      = (count_reg >= limit);
        status.has_head  = head_valid_reg;
        status.init_zero = (n_reg == '0);
        status.single    = (rd_prev_reg == {1'b0, head_reg})
                        && (rd_next_reg == {1'b0, head_reg});
        status.walk_last = (walk_reg == n_reg - CNT_W'(1));
    end

    // memory port selection per operation
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = head_reg;
        prev_we = 1'b0;
        prev_wa = item_reg;
        prev_wd = LINK_NIL;
        next_we = 1'b0;
        next_wa = item_reg;
        next_wd = LINK_NIL;
        case (cmd.op)
            OP_RD_HEAD:
            begin
                rd_en = 1'b1;
            end
            OP_RM_PICK:
            begin
                rd_en   = 1'b1;
                rd_addr = victim_next;
            end
            OP_INS_FIRST:
            begin
                prev_we = 1'b1;
                prev_wd = {1'b0, item_reg};
                next_we = 1'b1;
                next_wd = {1'b0, item_reg};
            end
            OP_INS_LINK:
            begin
                prev_we = 1'b1;
                prev_wd = {1'b0, rd_prev_reg[IDX_W-1:0]};
                next_we = 1'b1;
                next_wd = {1'b0, head_reg};
            end
            OP_INS_CLOSE:
            begin
                prev_we = 1'b1;
                prev_wa = head_reg;
                prev_wd = {1'b0, item_reg};
                next_we = 1'b1;
                next_wa = pv_reg;
                next_wd = {1'b0, item_reg};
            end
            OP_RM_SINGLE, OP_RM_NIL:
            begin
                prev_we = 1'b1;
                prev_wa = victim_reg;
                next_we = 1'b1;
                next_wa = victim_reg;
            end
            OP_RM_SPLICE:
            begin
                // bridge the neighbors with the victim's raw links
                next_we = 1'b1;
                next_wa = rd_prev_reg[IDX_W-1:0];
                next_wd = rd_next_reg;
                prev_we = 1'b1;
                prev_wa = rd_next_reg[IDX_W-1:0];
                prev_wd = rd_prev_reg;
            end
            OP_INIT_WALK:
            begin
                prev_we = 1'b1;
                prev_wa = walk_node;
                prev_wd = {1'b0, IDX_W'(walk_node - IDX_W'(1))};
                next_we = 1'b1;
                next_wa = walk_node;
                next_wd = {1'b0, IDX_W'(walk_node + IDX_W'(1))};
            end
            OP_INIT_CLOSE:
            begin
                prev_we = 1'b1;
                prev_wa = start_reg;
                prev_wd = {1'b0, last_node};
                next_we = 1'b1;
                next_wa = last_node;
                next_wd = {1'b0, start_reg};
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (rd_en)
        begin
            rd_prev_reg <= prev_mem[rd_addr];
            rd_next_reg <= next_mem[rd_addr];
        end
    end

    // payload registers of the command in flight
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                cmd_reg   <= request.command;
                item_reg  <= request.item_index;
                start_reg <= request.start_index;
                n_reg     <= req_n;
                walk_reg  <= '0;
            end
            OP_INS_LINK:
            begin
                pv_reg <= rd_prev_reg[IDX_W-1:0];
            end
            OP_RM_PICK:
            begin
                victim_reg <= victim_next;
            end
            OP_RM_SPLICE:
            begin
                // a victim that is its own predecessor got nil links
                succ_reg <= (rd_prev_reg[IDX_W-1:0] == victim_reg)
                          ? IDX_LAST : rd_next_reg[IDX_W-1:0];
            end
            OP_INIT_WALK:
            begin
                walk_reg <= walk_reg + CNT_W'(1);
            end
            OP_REPORT:
            begin
                resp_reg.removed_index <= removed_reg;
                resp_reg.removed_valid <= rvalid_reg;
                resp_reg.error         <= err_reg;
                resp_reg.head_index    <= head_valid_reg ? head_reg : '0;
                resp_reg.list_empty    <= !head_valid_reg;
                resp_reg.entry_count   <= count_reg;
            end
            default:
            begin
                walk_reg <= walk_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            head_valid_reg <= 1'b0;
            count_reg      <= '0;
            max_reg        <= POOL_SIZE;
            err_reg        <= 1'b0;
            removed_reg    <= '0;
            rvalid_reg     <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.op == OP_REPORT);
            if (cfg_we)
            begin
                max_reg <= cfg_data;
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    err_reg     <= 1'b0;
                    removed_reg <= '0;
                    rvalid_reg  <= 1'b0;
                end
                OP_SET_ERR:
                begin
                    err_reg <= 1'b1;
                end
                OP_INS_FIRST:
                begin
                    head_reg       <= item_reg;
                    head_valid_reg <= 1'b1;
                    count_reg      <= CNT_W'(1);
                end
                OP_INS_CLOSE:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    if (cmd_reg == CMD_INS_HEAD)
                    begin
                        head_reg <= item_reg;
                    end
                end
                OP_RM_SINGLE:
                begin
                    head_reg       <= '0;
                    head_valid_reg <= 1'b0;
                    count_reg      <= '0;
                    removed_reg    <= victim_reg;
                    rvalid_reg     <= 1'b1;
                end
                OP_RM_NIL:
                begin
                    if (count_reg != '0)
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                    if (cmd_reg != CMD_RM_TAIL)
                    begin
                        head_reg <= succ_reg;
                    end
                    removed_reg <= victim_reg;
                    rvalid_reg  <= 1'b1;
                end
                OP_INIT_EMPTY:
                begin
                    head_reg       <= '0;
                    head_valid_reg <= 1'b0;
                    count_reg      <= '0;
                end
                OP_INIT_CLOSE:
                begin
                    head_reg       <= start_reg;
                    head_valid_reg <= 1'b1;
                    count_reg      <= n_reg;
                end
                default:
                begin
                    err_reg <= err_reg;
                end
            endcase
        end
    end

    assign response = resp_reg;
    assign done     = done_reg;

endmodule

// ----- src/icdl_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the indexed circular doubly linked list, bound to the top level.
// Depends on icdl_pkg and the assertion macros header.
`include "indexed_circular_doubly_linked_list_assert.svh"

module icdl_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              done,
    input  icdl_pkg::result_t response
);
    import icdl_pkg::*;

    `ICDL_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "transfer did not raise busy")
    `ICDL_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy, "result shown while busy")
    `ICDL_ASSERT_SAME(a_remove_no_err, clk, rst_n, done && response.removed_valid, !response.error, "removal flagged as error")
    `ICDL_ASSERT_SAME(a_empty_status, clk, rst_n, done && response.list_empty, (response.head_index == '0) && (response.entry_count == '0), "empty list with head or count")

endmodule

bind indexed_circular_doubly_linked_list icdl_checker u_icdl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .response (response)
);

// ----- dv/indexed_circular_doubly_linked_list_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the indexed circular doubly linked list.
// Depends on icdl_pkg and the indexed_circular_doubly_linked_list top level.
module indexed_circular_doubly_linked_list_tb;
    import icdl_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int PHASES         = 7;
    localparam int ITEMS_PER_PHASE = 164;
    localparam int DRAIN_CYCLES   = 16;

    // Mirror of the ring: link stores, head, count, limit register.
    class ring_scoreboard;
        logic [LINK_W-1:0] prev_link [NODES];
        logic [LINK_W-1:0] next_link [NODES];
        bit                prev_set  [NODES];
        bit                next_set  [NODES];
        bit                on_ring   [NODES];
        logic [IDX_W-1:0]  head_node;
        bit                head_ok;
        logic [CNT_W-1:0]  entry_count;
        logic [CNT_W-1:0]  max_entries;
        result_t           expected_results [$];
        int                failures;

        function new();
            head_node   = '0;
            head_ok     = 0;
            entry_count = '0;
            max_entries = 11'd1024;
            failures    = 0;
            foreach (prev_set[i])
            begin
                prev_set[i] = 0;
                next_set[i] = 0;
                on_ring[i]  = 0;
                prev_link[i] = '0;
                next_link[i] = '0;
            end
        endfunction

        function void set_limit(logic [CNT_W-1:0] v);
            max_entries = v;
        endfunction

        function logic [CNT_W-1:0] cap();
            return (max_entries < NODES) ? max_entries : CNT_W'(NODES);
        endfunction

        function void clear_ring();
            head_ok     = 0;
            head_node   = '0;
            entry_count = '0;
            foreach (on_ring[i])
                on_ring[i] = 0;
        endfunction

        function void set_nil(logic [IDX_W-1:0] n);
            prev_link[n] = LINK_NIL;
            next_link[n] = LINK_NIL;
            prev_set[n]  = 1;
            next_set[n]  = 1;
            on_ring[n]   = 0;
        endfunction

        function void splice_in(logic [IDX_W-1:0] n);
            logic [IDX_W-1:0] nx;
            logic [IDX_W-1:0] pv;
            if (!head_ok)
            begin
                prev_link[n] = {1'b0, n};
                next_link[n] = {1'b0, n};
                head_node    = n;
                head_ok      = 1;
                entry_count  = '0;
            end
            else
            begin
                nx = head_node;
                pv = prev_link[nx][IDX_W-1:0];
                prev_link[n]  = {1'b0, pv};
                next_link[n]  = {1'b0, nx};
                prev_link[nx] = {1'b0, n};
                next_link[pv] = {1'b0, n};
                prev_set[nx]  = 1;
                next_set[pv]  = 1;
            end
            prev_set[n] = 1;
            next_set[n] = 1;
            on_ring[n]  = 1;
            entry_count = entry_count + 1'b1;
        endfunction

        // Unlink n from a ring of two or more; return its successor.
        function logic [IDX_W-1:0] splice_out(logic [IDX_W-1:0] n);
            logic [IDX_W-1:0] pv;
            logic [IDX_W-1:0] nx;
            pv = prev_link[n][IDX_W-1:0];
            nx = next_link[n][IDX_W-1:0];
            next_link[pv] = next_link[n];
            prev_link[nx] = prev_link[n];
            next_set[pv]  = 1;
            prev_set[nx]  = 1;
            set_nil(n);
            if (entry_count > 0)
                entry_count = entry_count - 1'b1;
            return next_link[pv][IDX_W-1:0];
        endfunction

        // True when the command would read a link entry never written.
        function bit touches_unwritten(request_t r);
            logic [IDX_W-1:0] victim;
            bit ok;
            if (!head_ok || r.command > CMD_RM_TAIL)
                return 0;
            ok = prev_set[head_node] && next_set[head_node];
            if (r.command == CMD_RM_ITEM)
                ok = ok && prev_set[r.item_index] && next_set[r.item_index];
            if (r.command == CMD_RM_TAIL && ok)
            begin
                victim = prev_link[head_node][IDX_W-1:0];
                ok = prev_set[victim] && next_set[victim];
            end
            return !ok;
        endfunction

        function result_t apply_command(request_t r);
            result_t          res;
            logic [IDX_W-1:0] victim;
            logic [IDX_W-1:0] succ;
            logic [IDX_W-1:0] node;
            logic [IDX_W-1:0] last_node;
            logic [CNT_W-1:0] run_len;
            res = '0;
            case (r.command)
                CMD_INS_HEAD, CMD_INS_TAIL:
                begin
                    if (entry_count >= cap())
                        res.error = 1'b1;
                    else
                    begin
                        splice_in(r.item_index);
                        if (r.command == CMD_INS_HEAD)
                            head_node = r.item_index;
                    end
                end
                CMD_RM_ITEM, CMD_RM_HEAD, CMD_RM_TAIL:
                begin
                    if (!head_ok)
                        res.error = 1'b1;
                    else
                    begin
                        if (r.command == CMD_RM_ITEM)
                            victim = r.item_index;
                        else if (r.command == CMD_RM_HEAD)
                            victim = head_node;
                        else
                            victim = prev_link[head_node][IDX_W-1:0];
                        if (prev_link[head_node] == {1'b0, head_node} &&
                            next_link[head_node] == {1'b0, head_node})
                        begin
                            set_nil(victim);
                            clear_ring();
                        end
                        else
                        begin
                            succ = splice_out(victim);
                            if (r.command != CMD_RM_TAIL)
                                head_node = succ;
                        end
                        res.removed_index = victim;
                        res.removed_valid = 1'b1;
                    end
                end
                CMD_INIT:
                begin
                    run_len = (r.init_count < cap()) ? r.init_count : cap();
                    clear_ring();
                    if (run_len != 0)
                    begin
                        for (int i = 0; i < run_len; i++)
                        begin
                            node = r.start_index + IDX_W'(i);
                            prev_link[node] = {1'b0, IDX_W'(node - 1'b1)};
                            next_link[node] = {1'b0, IDX_W'(node + 1'b1)};
                            prev_set[node]  = 1;
                            next_set[node]  = 1;
                            on_ring[node]   = 1;
                        end
                        last_node = r.start_index + IDX_W'(run_len - 1'b1);
                        prev_link[r.start_index] = {1'b0, last_node};
                        next_link[last_node]     = {1'b0, r.start_index};
                        head_node   = r.start_index;
                        head_ok     = 1;
                        entry_count = run_len;
                    end
                end
                default: ;
            endcase
            res.head_index  = head_ok ? head_node : '0;
            res.list_empty  = !head_ok;
            res.entry_count = entry_count;
            return res;
        endfunction

        function void note_request(request_t r);
            expected_results.push_back(apply_command(r));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result with nothing outstanding: %p", $realtime, got);
                return;
            end
            want = expected_results.pop_front();
            if (got.removed_index !== want.removed_index ||
                got.removed_valid !== want.removed_valid ||
                got.error !== want.error || got.head_index !== want.head_index ||
                got.list_empty !== want.list_empty ||
                got.entry_count !== want.entry_count)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch rm=%0d/%0b err=%0b head=%0d empty=%0b cnt=%0d, %s",
                             $realtime, got.removed_index, got.removed_valid, got.error,
                             got.head_index, got.list_empty, got.entry_count,
                             $sformatf("expected rm=%0d/%0b err=%0b head=%0d empty=%0b cnt=%0d",
                                       want.removed_index, want.removed_valid, want.error,
                                       want.head_index, want.list_empty, want.entry_count));
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    request_t         cmd_req;
    logic             done;
    result_t          cmd_rsp;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    ring_scoreboard sb;

    indexed_circular_doubly_linked_list uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (cmd_req),
        .done      (done),
        .response  (cmd_rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(cmd_rsp);
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    function automatic request_t make_cmd(logic [CMD_W-1:0] c, logic [IDX_W-1:0] item,
                                          logic [IDX_W-1:0] first, logic [CNT_W-1:0] len);
        request_t r;
        r.command     = c;
        r.item_index  = item;
        r.start_index = first;
        r.init_count  = len;
        return r;
    endfunction

    // Hold start high until the transfer, then record it.
    task automatic issue(request_t r);
        @(negedge clk);
        start   <= 1'b1;
        cmd_req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic hold_off(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_max_entries(logic [CNT_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_limit(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CNT_W-1:0] pick_init_len();
        if ($urandom_range(0, 99) < 3)
            return CNT_W'($urandom_range(0, 2047));
        return CNT_W'($urandom_range(0, 24));
    endfunction

    function automatic request_t make_random_cmd();
        request_t r;
        int roll;
        r.item_index  = IDX_W'($urandom);
        r.start_index = IDX_W'($urandom);
        r.init_count  = CNT_W'($urandom);
        if ($urandom_range(0, 99) < 15)
        begin
            r.command = CMD_W'($urandom_range(0, 7));
            if (r.command == CMD_INIT)
                r.init_count = pick_init_len();
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                r.command = CMD_INS_HEAD;
            else if (roll < 55)
                r.command = CMD_INS_TAIL;
            else if (roll < 70)
                r.command = CMD_RM_ITEM;
            else if (roll < 80)
                r.command = CMD_RM_HEAD;
            else if (roll < 90)
                r.command = CMD_RM_TAIL;
            else
            begin
                r.command    = CMD_INIT;
                r.init_count = pick_init_len();
            end
            // Prefer free nodes for inserts and members for removals.
            if (r.command == CMD_INS_HEAD || r.command == CMD_INS_TAIL)
            begin
                for (int t = 0; t < 8 && sb.on_ring[r.item_index]; t++)
                    r.item_index = IDX_W'($urandom);
            end
            else if (r.command == CMD_RM_ITEM)
            begin
                for (int t = 0; t < 16 && !sb.on_ring[r.item_index]; t++)
                    r.item_index = IDX_W'($urandom);
                if (!sb.on_ring[r.item_index] && sb.head_ok)
                    r.item_index = sb.head_node;
            end
        end
        // Replace anything that would read a link never written.
        if (sb.touches_unwritten(r))
        begin
            r.command    = CMD_INIT;
            r.init_count = CNT_W'($urandom_range(1, 16));
        end
        return r;
    endfunction

    task automatic run_directed();
        issue(make_cmd(CMD_RM_HEAD, 10'd0, 10'd0, 11'd0));
        issue(make_cmd(CMD_RM_TAIL, 10'd0, 10'd0, 11'd0));
        issue(make_cmd(CMD_RM_ITEM, 10'd5, 10'd0, 11'd0));
        issue(make_cmd(CMD_SPARE_6, 10'd1023, 10'd1023, 11'd2047));
        issue(make_cmd(CMD_SPARE_7, 10'd0, 10'd0, 11'd0));
        issue(make_cmd(CMD_INIT, 10'd0, 10'd100, 11'd0));
        issue(make_cmd(CMD_INIT, 10'd0, 10'd1023, 11'd1));
        issue(make_cmd(CMD_RM_ITEM, 10'd1023, 10'd0, 11'd0));
        issue(make_cmd(CMD_INS_HEAD, 10'd0, 10'd0, 11'd0));
        issue(make_cmd(CMD_INS_TAIL, 10'd1023, 10'd0, 11'd0));
        issue(make_cmd(CMD_INS_HEAD, 10'd512, 10'd0, 11'd0));
        issue(make_cmd(CMD_RM_TAIL, 10'd0, 10'd0, 11'd0));
        issue(make_cmd(CMD_RM_HEAD, 10'd0, 10'd0, 11'd0));
        issue(make_cmd(CMD_RM_ITEM, 10'd0, 10'd0, 11'd0));
        // Run that wraps past the top of the pool.
        issue(make_cmd(CMD_INIT, 10'd0, 10'd1020, 11'd8));
        issue(make_cmd(CMD_RM_ITEM, 10'd1022, 10'd0, 11'd0));
        issue(make_cmd(CMD_RM_TAIL, 10'd0, 10'd0, 11'd0));
        issue(make_cmd(CMD_RM_HEAD, 10'd0, 10'd0, 11'd0));
        issue(make_cmd(CMD_INS_TAIL, 10'd1022, 10'd0, 11'd0));
        // Oversized run saturates to a full pool; inserts then fail.
        issue(make_cmd(CMD_INIT, 10'd0, 10'd0, 11'd2047));
        issue(make_cmd(CMD_INS_HEAD, 10'd5, 10'd0, 11'd0));
        issue(make_cmd(CMD_INS_TAIL, 10'd6, 10'd0, 11'd0));
        issue(make_cmd(CMD_RM_ITEM, 10'd300, 10'd0, 11'd0));
        // Single-entry ring emptied through a node that is not its member.
        issue(make_cmd(CMD_INIT, 10'd0, 10'd7, 11'd1));
        issue(make_cmd(CMD_RM_ITEM, 10'd300, 10'd0, 11'd0));
        issue(make_cmd(CMD_INIT, 10'h155, 10'h2AA, 11'h555));
    endtask

    initial
    begin
        logic [CNT_W-1:0] limits [PHASES];
        bit quiet;
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd_req   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        sb        = new();
        limits[0] = 11'd1;
        limits[1] = 11'd2;
        limits[2] = CNT_W'($urandom_range(3, 40));
        limits[3] = 11'd1024;
        limits[4] = CNT_W'($urandom_range(1, 1024));
        limits[5] = 11'd16;
        limits[6] = 11'd1024;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        for (int p = 0; p < PHASES; p++)
        begin
            write_max_entries(limits[p]);
            quiet = (p == PHASES - 1);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (!quiet && $urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 3));
                if (!quiet && $urandom_range(0, 99) == 0)
                    drain();
                issue(make_random_cmd());
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
